>>> hw/rtl/hma_pkg.sv
// ---------------------------------------------------------------------------
// hma_pkg
// Shared types and constants of the histogram moment accumulator.
// ---------------------------------------------------------------------------
package hma_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int PROD_W      = 48;
  localparam int SUM_W       = 64;
  localparam int CNT_W       = 32;
  localparam int IDX_W       = 6;
  localparam int STEP_W      = 31;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_CNT_W   = 6;

  // Binning modes; code 3 falls back to the breakpoint scan
  localparam logic [1:0] MODE_SCAN   = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_GEO    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXACT_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_STEP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKETS_USED = 3'd5;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_READ   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]                 bin_mode;
    logic [15:0]                scale_factor;
    logic [6:0]                 exact_count;
    logic signed [SAMPLE_W-1:0] range_start;
    logic [STEP_W-1:0]          range_step;
    logic [6:0]                 buckets_used;
  } cfg_t;

  // One queued word from front to back
  typedef struct packed {
    kind_t                      kind;
    logic signed [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]           idx;
    logic                       idx_ok;
    logic signed [SAMPLE_W-1:0] bval;
    logic signed [PROD_W-1:0]   prod;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SEL,
    ST_SC_RD,
    ST_SC_CHK,
    ST_EX_RD,
    ST_EX_CHK,
    ST_BS_INIT,
    ST_BS_TOP,
    ST_BS_RD,
    ST_BS_CHK,
    ST_DIV,
    ST_DIV_FIN,
    ST_CNT_RD,
    ST_CNT_WR
  } back_state_t;

endpackage

>>> hw/rtl/hma_front.sv
// ---------------------------------------------------------------------------
// hma_front
// Accepts commands, scales the sample into a bin product and classifies the
// entry index, then hands the word to the queue.
// ---------------------------------------------------------------------------
module hma_front #(
  parameter int MAX_BUCKETS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_kind,
  input  logic signed [hma_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [hma_pkg::IDX_W-1:0]           in_entry_index,
  input  logic signed [hma_pkg::SAMPLE_W-1:0] in_boundary_value,
  input  logic [15:0]                         scale_factor,
  input  logic                                q_full,
  output logic                                q_push,
  output hma_pkg::item_t                      q_item
);
  import hma_pkg::*;

  logic                     hold_r;
  item_t                    item_r;
  logic                     accept;
  logic signed [PROD_W:0]   prod_full;

  // Stall only when a word is held and the queue cannot take it
  assign busy   = hold_r && q_full;
  assign accept = start && !busy;
  assign q_push = hold_r && !q_full;
  assign q_item = item_r;

  assign prod_full = in_sample * $signed({1'b0, scale_factor});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else if (accept) begin
      hold_r <= 1'b1;
    end else if (q_push) begin
      hold_r <= 1'b0;
    end
  end

  // Capture and classify the word
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.kind   <= kind_t'(in_kind);
      item_r.sample <= in_sample;
      item_r.idx    <= in_entry_index;
      item_r.idx_ok <= (32'(in_entry_index) < MAX_BUCKETS);
      item_r.bval   <= in_boundary_value;
      item_r.prod   <= prod_full[PROD_W-1:0];
    end
  end

endmodule

>>> hw/rtl/hma_queue.sv
// ---------------------------------------------------------------------------
// hma_queue
// Short FIFO of command words between front and back.
// ---------------------------------------------------------------------------
module hma_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hma_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output hma_pkg::item_t pop_item,
  output logic           empty
);
  import hma_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [LVL_W-1:0] level_r;

  assign full     = (32'(level_r) == QUEUE_DEPTH);
  assign empty    = (level_r == '0);
  assign pop_item = slot_r[rd_ptr_r];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        level_r <= level_r + LVL_W'(1);
      end else if (pop && !push) begin
        level_r <= level_r - LVL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> hw/rtl/hma_back.sv
// ---------------------------------------------------------------------------
// hma_back
// Executes queued words: moment update, bucket selection by table scan,
// serial division or binary search, bucket count update and the result word.
// ---------------------------------------------------------------------------
module hma_back #(
  parameter int MAX_BUCKETS = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hma_pkg::cfg_t                       cfg,
  input  logic                                q_empty,
  input  hma_pkg::item_t                      q_item,
  output logic                                q_pop,
  output logic                                out_valid,
  output logic [hma_pkg::IDX_W-1:0]           out_bucket,
  output logic [hma_pkg::CNT_W-1:0]           out_bucket_count,
  output logic [hma_pkg::CNT_W-1:0]           out_sample_count,
  output logic signed [hma_pkg::SUM_W-1:0]    out_value_sum,
  output logic [hma_pkg::SUM_W-1:0]           out_square_sum,
  output logic signed [hma_pkg::SAMPLE_W-1:0] out_max_value
);
  import hma_pkg::*;

  localparam int BIDX_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NB_W   = BIDX_W + 1;

  back_state_t state_r, state_nxt;
  item_t       cur_r;

  logic signed [PROD_W-1:0] iv_r, iv_nxt;
  logic [SUM_W-1:0]         sq_r, sq_nxt;
  logic [NB_W-1:0]          i_r, i_nxt;
  logic [NB_W-1:0]          top_r, top_nxt;
  logic [NB_W-1:0]          bot_r, bot_nxt;
  logic [NB_W-1:0]          mid_r, mid_nxt;
  logic [NB_W-1:0]          b_r, b_nxt;
  logic [SAMPLE_W-1:0]      rem_r, rem_nxt;
  logic [PROD_W-1:0]        quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0]     dcnt_r, dcnt_nxt;

  logic [CNT_W-1:0]          count_r, count_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SUM_W-1:0]          sqs_r, sqs_nxt;
  logic signed [SAMPLE_W-1:0] max_r, max_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_bucket_r, out_bucket_nxt;
  logic [CNT_W-1:0]  out_bcnt_r, out_bcnt_nxt;

  // Table and count memories
  logic signed [SAMPLE_W-1:0] tbl_mem [MAX_BUCKETS];
  logic signed [SAMPLE_W-1:0] tbl_q_r;
  logic [CNT_W-1:0]           cnt_mem [MAX_BUCKETS];
  logic [CNT_W-1:0]           cnt_q_r;
  logic [MAX_BUCKETS-1:0]     valid_r;
  logic                       cnt_vld_q_r;

  logic [BIDX_W-1:0] tbl_raddr;
  logic              tbl_we;
  logic [BIDX_W-1:0] cnt_raddr;
  logic              cnt_we;
  logic              clr_all;

  // Derived configuration
  logic [NB_W-1:0]          nb, nb_m1, nb_m2, eq;
  logic signed [PROD_W-1:0] start_ext;
  logic [STEP_W-1:0]        step_eff;
  logic                     is_lin, is_geo;

  // Datapath helpers
  logic [NB_W+IDX_W-1:0]    idx_ext;
  logic [BIDX_W-1:0]        idx_addr;
  logic [BIDX_W-1:0]        b_addr;
  logic [NB_W+IDX_W-1:0]    b_ext;
  logic                     prod_neg;
  logic [PROD_W-1:0]        prod_mag, mag_sh;
  logic signed [PROD_W-1:0] iv_calc;
  logic signed [SUM_W-1:0]  sq_calc;
  logic signed [PROD_W-1:0] tbl_ext;
  logic                     iv_lt, iv_eq, iv_below;
  logic signed [SUM_W-1:0]  s64, e64;
  logic                     s_eq, sc_match;
  logic [NB_W-1:0]          mid_calc, bs_top, bs_bot;
  logic [SAMPLE_W-1:0]      trial;
  logic                     trial_ge;
  logic [PROD_W-1:0]        d_calc;
  logic                     div_hit;
  logic [PROD_W:0]          k_calc;
  logic [CNT_W-1:0]         cur_cnt, cnt_inc;
  logic signed [SUM_W-1:0]  sum_add;
  logic                     sum_ovf;
  logic [SUM_W:0]           sqs_add;

  // Clamp bucket count and exact count
  always_comb begin
    if (cfg.buckets_used < 7'd2) begin
      nb = NB_W'(2);
    end else if (32'(cfg.buckets_used) > MAX_BUCKETS) begin
      nb = NB_W'(MAX_BUCKETS);
    end else begin
      nb = NB_W'(cfg.buckets_used);
    end
    if (32'(cfg.exact_count) > 32'(nb)) begin
      eq = nb;
    end else begin
      eq = NB_W'(cfg.exact_count);
    end
    nb_m1     = nb - NB_W'(1);
    nb_m2     = nb - NB_W'(2);
    start_ext = PROD_W'(cfg.range_start);
    step_eff  = (cfg.range_step == '0) ? STEP_W'(1) : cfg.range_step;
    is_lin    = (cfg.bin_mode == MODE_LINEAR);
    is_geo    = (cfg.bin_mode == MODE_GEO);
  end

  // Shared datapath terms
  always_comb begin
    idx_ext  = {{NB_W{1'b0}}, cur_r.idx};
    idx_addr = idx_ext[BIDX_W-1:0];
    b_addr   = b_r[BIDX_W-1:0];
    b_ext    = {{IDX_W{1'b0}}, b_r};

    prod_neg = cur_r.prod[PROD_W-1];
    prod_mag = prod_neg ? PROD_W'(-cur_r.prod) : PROD_W'(cur_r.prod);
    mag_sh   = prod_mag >> FRAC_BITS;
    iv_calc  = prod_neg ? -$signed(mag_sh) : $signed(mag_sh);
    sq_calc  = cur_r.sample * cur_r.sample;

    tbl_ext  = PROD_W'(tbl_q_r);
    iv_lt    = (iv_r < tbl_ext);
    iv_eq    = (iv_r == tbl_ext);
    iv_below = (iv_r < start_ext);

    s64      = SUM_W'(cur_r.sample);
    e64      = SUM_W'(tbl_q_r) <<< FRAC_BITS;
    s_eq     = (s64 == e64);
    sc_match = (i_r < eq) ? s_eq : iv_lt;

    mid_calc = bot_r + ((top_r - bot_r) >> 1);
    if (iv_lt) begin
      bs_top = mid_r;
      bs_bot = bot_r;
    end else begin
      bs_top = top_r;
      bs_bot = mid_r + NB_W'(1);
    end

    trial    = {rem_r[SAMPLE_W-2:0], quo_r[PROD_W-1]};
    trial_ge = (trial >= {1'b0, step_eff});
    d_calc   = PROD_W'(iv_r - start_ext);
    div_hit  = (eq != '0) && (rem_r == '0) && (quo_r <= PROD_W'(eq - NB_W'(1)));
    k_calc   = div_hit ? {1'b0, quo_r} : {1'b0, quo_r} + (PROD_W+1)'(1);

    cur_cnt  = cnt_vld_q_r ? cnt_q_r : '0;
    cnt_inc  = (cur_cnt == '1) ? cur_cnt : cur_cnt + CNT_W'(1);

    sum_add  = sum_r + s64;
    sum_ovf  = (sum_r[SUM_W-1] == s64[SUM_W-1]) && (sum_add[SUM_W-1] != s64[SUM_W-1]);
    sqs_add  = {1'b0, sqs_r} + {1'b0, sq_r};
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        unique case (cur_r.kind)
          KIND_SAMPLE: state_nxt = ST_SEL;
          KIND_LOAD:   state_nxt = ST_CNT_RD;
          KIND_READ:   state_nxt = ST_CNT_RD;
          KIND_CLEAR:  state_nxt = ST_IDLE;
          default:     state_nxt = ST_IDLE;
        endcase
      end
      ST_SEL: begin
        priority if ((is_lin || is_geo) && iv_below) begin
          state_nxt = ST_CNT_RD;
        end else if (is_lin) begin
          state_nxt = ST_DIV;
        end else if (is_geo) begin
          state_nxt = (eq != '0) ? ST_EX_RD : ST_BS_INIT;
        end else begin
          state_nxt = ST_SC_RD;
        end
      end
      ST_SC_RD:  state_nxt = ST_SC_CHK;
      ST_SC_CHK: begin
        state_nxt = (sc_match || i_r == nb_m2) ? ST_CNT_RD : ST_SC_RD;
      end
      ST_EX_RD:  state_nxt = ST_EX_CHK;
      ST_EX_CHK: begin
        priority if (iv_eq) begin
          state_nxt = ST_CNT_RD;
        end else if (i_r == eq - NB_W'(1)) begin
          state_nxt = ST_BS_INIT;
        end else begin
          state_nxt = ST_EX_RD;
        end
      end
      ST_BS_INIT: state_nxt = (eq <= nb_m2) ? ST_BS_TOP : ST_CNT_RD;
      ST_BS_TOP:  state_nxt = (iv_lt && top_r != bot_r) ? ST_BS_RD : ST_CNT_RD;
      ST_BS_RD:   state_nxt = ST_BS_CHK;
      ST_BS_CHK:  state_nxt = (bs_top == bs_bot) ? ST_CNT_RD : ST_BS_RD;
      ST_DIV: begin
        if (32'(dcnt_r) == PROD_W - 1) state_nxt = ST_DIV_FIN;
      end
      ST_DIV_FIN: state_nxt = ST_CNT_RD;
      ST_CNT_RD:  state_nxt = ST_CNT_WR;
      ST_CNT_WR:  state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Memory and queue controls
  always_comb begin
    q_pop     = (state_r == ST_IDLE) && !q_empty;
    tbl_we    = (state_r == ST_PREP) && (cur_r.kind == KIND_LOAD) && cur_r.idx_ok;
    clr_all   = (state_r == ST_PREP) && (cur_r.kind == KIND_CLEAR);
    cnt_we    = (state_r == ST_CNT_WR) && (cur_r.kind == KIND_SAMPLE);
    cnt_raddr = (cur_r.kind == KIND_SAMPLE) ? b_addr : idx_addr;
    unique case (state_r)
      ST_BS_INIT: tbl_raddr = nb_m2[BIDX_W-1:0];
      ST_BS_RD: begin
        tbl_raddr = BIDX_W'(mid_calc + NB_W'(1));
      end
      default:    tbl_raddr = i_r[BIDX_W-1:0];
    endcase
  end

  // Datapath next values
  always_comb begin
    iv_nxt         = iv_r;
    sq_nxt         = sq_r;
    i_nxt          = i_r;
    top_nxt        = top_r;
    bot_nxt        = bot_r;
    mid_nxt        = mid_r;
    b_nxt          = b_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    dcnt_nxt       = dcnt_r;
    count_nxt      = count_r;
    sum_nxt        = sum_r;
    sqs_nxt        = sqs_r;
    max_nxt        = max_r;
    out_valid_nxt  = 1'b0;
    out_bucket_nxt = out_bucket_r;
    out_bcnt_nxt   = out_bcnt_r;
    unique case (state_r)
      ST_PREP: begin
        iv_nxt = iv_calc;
        sq_nxt = SUM_W'(sq_calc);
        if (cur_r.kind == KIND_CLEAR) begin
          count_nxt      = '0;
          sum_nxt        = '0;
          sqs_nxt        = '0;
          max_nxt        = '0;
          out_valid_nxt  = 1'b1;
          out_bucket_nxt = cur_r.idx;
          out_bcnt_nxt   = '0;
        end
      end
      ST_SEL: begin
        i_nxt    = '0;
        b_nxt    = '0;
        rem_nxt  = '0;
        quo_nxt  = d_calc;
        dcnt_nxt = '0;
      end
      ST_SC_CHK: begin
        if (sc_match) begin
          b_nxt = i_r;
        end else if (i_r == nb_m2) begin
          b_nxt = nb_m1;
        end else begin
          i_nxt = i_r + NB_W'(1);
        end
      end
      ST_EX_CHK: begin
        if (iv_eq) begin
          b_nxt = i_r;
        end else begin
          i_nxt = i_r + NB_W'(1);
        end
      end
      ST_BS_INIT: begin
        top_nxt = nb_m2;
        bot_nxt = eq;
        b_nxt   = nb_m1;
      end
      ST_BS_TOP: begin
        b_nxt = top_r + NB_W'(1);
      end
      ST_BS_RD: begin
        mid_nxt = mid_calc;
      end
      ST_BS_CHK: begin
        top_nxt = bs_top;
        bot_nxt = bs_bot;
        b_nxt   = bs_top + NB_W'(1);
      end
      ST_DIV: begin
        rem_nxt  = trial_ge ? trial - {1'b0, step_eff} : trial;
        quo_nxt  = {quo_r[PROD_W-2:0], trial_ge};
        dcnt_nxt = dcnt_r + DIV_CNT_W'(1);
      end
      ST_DIV_FIN: begin
        if (k_calc >= (PROD_W+1)'(nb)) begin
          b_nxt = nb_m1;
        end else begin
          b_nxt = k_calc[NB_W-1:0];
        end
      end
      ST_CNT_WR: begin
        out_valid_nxt = 1'b1;
        if (cur_r.kind == KIND_SAMPLE) begin
          count_nxt      = (count_r == '1) ? count_r : count_r + CNT_W'(1);
          max_nxt        = (cur_r.sample > max_r) ? cur_r.sample : max_r;
          if (sum_ovf) begin
            sum_nxt = s64[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
          end else begin
            sum_nxt = sum_add;
          end
          sqs_nxt        = sqs_add[SUM_W] ? '1 : sqs_add[SUM_W-1:0];
          out_bucket_nxt = b_ext[IDX_W-1:0];
          out_bcnt_nxt   = cnt_inc;
        end else begin
          out_bucket_nxt = cur_r.idx;
          out_bcnt_nxt   = cur_r.idx_ok ? cur_cnt : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      sum_r       <= '0;
      sqs_r       <= '0;
      max_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      sqs_r       <= sqs_nxt;
      max_r       <= max_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_item;
    iv_r         <= iv_nxt;
    sq_r         <= sq_nxt;
    i_r          <= i_nxt;
    top_r        <= top_nxt;
    bot_r        <= bot_nxt;
    mid_r        <= mid_nxt;
    b_r          <= b_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    dcnt_r       <= dcnt_nxt;
    out_bucket_r <= out_bucket_nxt;
    out_bcnt_r   <= out_bcnt_nxt;
  end

  // Boundary table
  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[idx_addr] <= cur_r.bval;
    tbl_q_r <= tbl_mem[tbl_raddr];
  end

  // Bucket counts
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[b_addr] <= cnt_inc;
    cnt_q_r     <= cnt_mem[cnt_raddr];
    cnt_vld_q_r <= valid_r[cnt_raddr];
  end

  // Drop all counts at once on reset or clear
  always_ff @(posedge clk) begin
    if (!rst_n || clr_all) begin
      valid_r <= '0;
    end else if (cnt_we) begin
      valid_r[b_addr] <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_bucket       = out_bucket_r;
  assign out_bucket_count = out_bcnt_r;
  assign out_sample_count = count_r;
  assign out_value_sum    = sum_r;
  assign out_square_sum   = sqs_r;
  assign out_max_value    = max_r;

endmodule

>>> hw/rtl/histogram_moment_accumulator.sv
// ---------------------------------------------------------------------------
// histogram_moment_accumulator
// Histogram with running count, sum, sum of squares and maximum.
// ---------------------------------------------------------------------------
// Usage:
//   Commands enter on start/busy: a word is taken at a clock edge with start
//   high and busy low. in_kind selects sample, table load, bucket read or
//   clear. Every command yields one result word on the out_ ports, marked by
//   a one-cycle out_valid strobe; the receiver must take it in that cycle.
//   Configuration registers are written on cfg_valid/cfg_ready (always
//   ready); the user must write them only while no command is in flight,
//   which the block itself does not enforce. With the engine idle, clear
//   finishes in the decode state; load and read pass decode, a count read
//   and a count write. Samples add a select state plus the bucket choice:
//   breakpoint scan reads and checks one table entry at a time (one table
//   memory port), linear mode runs a 48-step bit-serial divider, geometric
//   mode checks each exact-match entry, then runs a binary search.
//   A two-word queue sits between the input stage and the execution engine,
//   so from idle up to four commands can be taken before busy rises; the
//   throughput equals the execution time per command.
//   Reset empties the queue, zeroes statistics and marks every bucket count
//   zero at once; the boundary table holds no defined value until loaded.
// ---------------------------------------------------------------------------
module histogram_moment_accumulator #(
  parameter int MAX_BUCKETS = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            in_kind,
  input  logic signed [hma_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic [hma_pkg::IDX_W-1:0]             in_entry_index,
  input  logic signed [hma_pkg::SAMPLE_W-1:0]   in_boundary_value,
  output logic                                  out_valid,
  output logic [hma_pkg::IDX_W-1:0]             out_bucket,
  output logic [hma_pkg::CNT_W-1:0]             out_bucket_count,
  output logic [hma_pkg::CNT_W-1:0]             out_sample_count,
  output logic signed [hma_pkg::SUM_W-1:0]      out_value_sum,
  output logic [hma_pkg::SUM_W-1:0]             out_square_sum,
  output logic signed [hma_pkg::SAMPLE_W-1:0]   out_max_value,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [hma_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [hma_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import hma_pkg::*;

  cfg_t  cfg_r;
  logic  q_full, q_push, q_pop, q_empty;
  item_t push_item, pop_item;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bin_mode     <= MODE_SCAN;
      cfg_r.scale_factor <= 16'd1;
      cfg_r.exact_count  <= 7'd0;
      cfg_r.range_start  <= '0;
      cfg_r.range_step   <= STEP_W'(1);
      cfg_r.buckets_used <= 7'd10;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BIN_MODE:     cfg_r.bin_mode     <= cfg_data[1:0];
        CFG_SCALE_FACTOR: cfg_r.scale_factor <= cfg_data[15:0];
        CFG_EXACT_COUNT:  cfg_r.exact_count  <= cfg_data[6:0];
        CFG_RANGE_START:  cfg_r.range_start  <= $signed(cfg_data);
        CFG_RANGE_STEP:   cfg_r.range_step   <= cfg_data[STEP_W-1:0];
        CFG_BUCKETS_USED: cfg_r.buckets_used <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  hma_front #(
    .MAX_BUCKETS(MAX_BUCKETS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_sample         (in_sample),
    .in_entry_index    (in_entry_index),
    .in_boundary_value (in_boundary_value),
    .scale_factor      (cfg_r.scale_factor),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_item            (push_item)
  );

  hma_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  hma_back #(
    .MAX_BUCKETS(MAX_BUCKETS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_empty          (q_empty),
    .q_item           (pop_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_bucket       (out_bucket),
    .out_bucket_count (out_bucket_count),
    .out_sample_count (out_sample_count),
    .out_value_sum    (out_value_sum),
    .out_square_sum   (out_square_sum),
    .out_max_value    (out_max_value)
  );

`ifndef SYNTHESIS
  // Every command passes through the idle state, so strobes never touch
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // With no samples counted the sums must be empty
  a_empty_sums: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_sample_count == '0) |-> (out_value_sum == '0 && out_square_sum == '0))
    else $error("sums nonzero with zero sample count");

  // Maximum starts at zero and can only grow until a clear resets it
  a_max_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_max_value[SAMPLE_W-1])
    else $error("running maximum went negative");
`endif

endmodule

>>> verif/histogram_moment_accumulator_tb.sv
// ---------------------------------------------------------------------------
// histogram_moment_accumulator_tb
// Drives sample, table load, bucket read and clear words through the
// start/busy port under several binning setups and idle patterns, predicts
// each result word in a local model of the histogram and its running
// moments, and compares every strobed result field by field.
// ---------------------------------------------------------------------------
module histogram_moment_accumulator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hma_pkg::*;

  localparam int NBKT = 64;
  localparam int FRAC = 16;
  localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_MIN = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic [5:0]         bucket;
    logic [31:0]        bcount;
    logic [31:0]        scount;
    longint             vsum;
    longint unsigned    sqsum;
    int                 maxv;
  } tally_t;

  typedef struct {
    kind_t      kind;
    int         smp;
    bit [5:0]   ix;
    int         bval;
    bit         zero_exp;
  } row_t;

  typedef struct {
    bit [1:0]   mode;
    int         scale;
    int         exact;
    int         rstart;
    int         rstep;
    int         used;
    int         idle_pct;
    int         n;
  } setup_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_kind = '0;
  logic signed [31:0] in_sample = '0;
  logic [5:0] in_entry_index = '0;
  logic signed [31:0] in_boundary_value = '0;
  logic out_valid;
  logic [5:0] out_bucket;
  logic [31:0] out_bucket_count, out_sample_count;
  logic signed [63:0] out_value_sum;
  logic [63:0] out_square_sum;
  logic signed [31:0] out_max_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // model state
  bit [1:0] m_mode;
  int unsigned m_scale, m_exact, m_step, m_used;
  int m_start;
  int unsigned m_count;
  longint m_sum;
  longint unsigned m_squares;
  int m_max;
  int unsigned m_bins [NBKT];
  int m_table [NBKT];

  tally_t pending_words[$];
  int errors = 0;
  int idle_pct = 0;

  always #2 clk = ~clk;

  histogram_moment_accumulator u_dut (
    .clk, .rst_n, .start, .busy, .in_kind, .in_sample, .in_entry_index,
    .in_boundary_value, .out_valid, .out_bucket, .out_bucket_count,
    .out_sample_count, .out_value_sum, .out_square_sum, .out_max_value,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // Truncate sample times scale toward zero at the fraction point
  function automatic longint bin_of(int s);
    longint p;
    longint unsigned mag;
    p = longint'(s) * longint'(m_scale);
    mag = (p < 0) ? longint'(-p) : p;
    mag = mag >> FRAC;
    return (p < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic int pick_bucket(int s, longint iv, int nb);
    int eq, top, bottom, mid, k;
    longint stp, d, q;
    eq = (m_exact > nb) ? nb : m_exact;
    stp = (m_step == 0) ? 64'sd1 : longint'(m_step);
    if ((m_mode == MODE_LINEAR || m_mode == MODE_GEO) && iv < longint'(m_start))
      return 0;
    if (m_mode == MODE_LINEAR) begin
      d = iv - longint'(m_start);
      if (eq > 0 && d <= stp * (eq - 1) && (d % stp) == 0) q = d / stp;
      else q = d / stp + 1;
      return (q >= nb) ? nb - 1 : int'(q);
    end
    if (m_mode == MODE_GEO) begin
      for (k = 0; k < eq; k++)
        if (iv == longint'(m_table[k])) return k;
      top = nb - 2;
      bottom = eq;
      if (bottom <= top && iv < longint'(m_table[top])) begin
        while (top != bottom) begin
          mid = bottom + (top - bottom) / 2;
          if (iv < longint'(m_table[mid + 1])) top = mid;
          else bottom = mid + 1;
        end
      end
      return (top + 1 >= nb) ? nb - 1 : top + 1;
    end
    // breakpoint scan, also taken by the unused mode code
    for (k = 0; k < nb - 1; k++) begin
      if (k < eq) begin
        if (longint'(s) == longint'(m_table[k]) * (64'sd1 << FRAC)) return k;
      end else if (iv < longint'(m_table[k])) begin
        return k;
      end
    end
    return nb - 1;
  endfunction

  // Advance the model by one word and return the result it yields
  function automatic tally_t apply_word(kind_t k, int s, bit [5:0] ix, int bv);
    tally_t r;
    int nb, b;
    longint sq;
    r.bucket = ix;
    r.bcount = 0;
    case (k)
      KIND_SAMPLE: begin
        nb = (m_used < 2) ? 2 : (m_used > NBKT) ? NBKT : m_used;
        if (m_count != 32'hFFFF_FFFF) m_count++;
        if (s > m_max) m_max = s;
        if (s > 0 && m_sum > SUM_MAX - s) m_sum = SUM_MAX;
        else if (s < 0 && m_sum < SUM_MIN - s) m_sum = SUM_MIN;
        else m_sum += s;
        sq = longint'(s) * longint'(s);
        if (m_squares > 64'hFFFF_FFFF_FFFF_FFFF - sq) m_squares = '1;
        else m_squares += sq;
        b = pick_bucket(s, bin_of(s), nb);
        if (m_bins[b] != 32'hFFFF_FFFF) m_bins[b]++;
        r.bucket = 6'(b);
        r.bcount = m_bins[b];
      end
      KIND_LOAD: begin
        m_table[ix] = bv;
        r.bcount = m_bins[ix];
      end
      KIND_READ: r.bcount = m_bins[ix];
      default: begin
        m_count = 0;
        m_sum = 0;
        m_squares = 0;
        m_max = 0;
        foreach (m_bins[i]) m_bins[i] = 0;
      end
    endcase
    r.scount = m_count;
    r.vsum = m_sum;
    r.sqsum = m_squares;
    r.maxv = m_max;
    return r;
  endfunction

  // Hand one word to the block; hold start until busy is low at an edge
  task automatic send_word(kind_t k, int s, bit [5:0] ix, int bv, bit zero_exp);
    tally_t e;
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      @(negedge clk) start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    in_kind = k;
    in_sample = s;
    in_entry_index = ix;
    in_boundary_value = bv;
    do @(posedge clk); while (busy);
    e = apply_word(k, s, ix, bv);
    if (zero_exp) e = '{bucket: ix, bcount: 0, scount: 0, vsum: 0, sqsum: 0, maxv: 0};
    pending_words.push_back(e);
  endtask

  // Drop start and hold until every pending result has come back
  task automatic drain();
    @(negedge clk) start = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BIN_MODE:     m_mode = val[1:0];
      CFG_SCALE_FACTOR: m_scale = 32'(val[15:0]);
      CFG_EXACT_COUNT:  m_exact = 32'(val[6:0]);
      CFG_RANGE_START:  m_start = val;
      CFG_RANGE_STEP:   m_step = 32'(val[30:0]);
      CFG_BUCKETS_USED: m_used = 32'(val[6:0]);
      default: ;
    endcase
    @(negedge clk) cfg_valid = 1'b0;
  endtask

  // Aim samples at the table, the linear grid, a small range around zero or anywhere
  function automatic int make_sample();
    longint t, v;
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 2) return $urandom;
    if (sel < 4) return m_table[$urandom_range(NBKT - 1)] <<< FRAC;
    if (sel == 4)
      t = longint'(m_start) +
          longint'($urandom_range(8)) * ((m_step == 0) ? 64'sd1 : longint'(m_step));
    else
      t = longint'($urandom_range(320)) - 160;
    v = ((t <<< FRAC) + longint'($urandom_range(65535))) / longint'(m_scale);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return int'(v);
  endfunction

  // Check each strobed word against the oldest expectation
  always @(posedge clk) begin
    tally_t e;
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        $error("result word with nothing pending");
        errors++;
      end else begin
        e = pending_words.pop_front();
        if (out_bucket !== e.bucket) begin
          $error("bucket: expected %0d, got %0d", e.bucket, out_bucket);
          errors++;
        end
        if (out_bucket_count !== e.bcount) begin
          $error("bucket_count: expected %0d, got %0d", e.bcount, out_bucket_count);
          errors++;
        end
        if (out_sample_count !== e.scount) begin
          $error("sample_count: expected %0d, got %0d", e.scount, out_sample_count);
          errors++;
        end
        if (out_value_sum !== e.vsum) begin
          $error("value_sum: expected %0d, got %0d", e.vsum, out_value_sum);
          errors++;
        end
        if (out_square_sum !== e.sqsum) begin
          $error("square_sum: expected %0d, got %0d", e.sqsum, out_square_sum);
          errors++;
        end
        if (out_max_value !== e.maxv) begin
          $error("max_value: expected %0d, got %0d", e.maxv, out_max_value);
          errors++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    row_t dir_rows[$];
    setup_t setups[$];
    kind_t k;
    int unsigned sel;
    bit [5:0] ix;
    int bv;

    m_mode = MODE_SCAN; m_scale = 1; m_exact = 0;
    m_start = 0; m_step = 1; m_used = 10;
    void'(apply_word(KIND_CLEAR, 0, 0, 0));

    // edge values, square-sum saturation, loads, reads and clears
    dir_rows = '{
      '{KIND_SAMPLE, 32'h7FFF_FFFF, 0, 0, 0},
      '{KIND_SAMPLE, 32'h8000_0000, 1, 0, 0},
      '{KIND_SAMPLE, 32'h8000_0000, 2, 0, 0},
      '{KIND_SAMPLE, 32'h8000_0000, 3, 0, 0},
      '{KIND_SAMPLE, 32'h8000_0000, 4, 0, 0},
      '{KIND_SAMPLE, 32'h8000_0000, 5, 0, 0},
      '{KIND_SAMPLE, 0, 0, 0, 0},
      '{KIND_SAMPLE, -1, 0, 0, 0},
      '{KIND_SAMPLE, 1, 0, 0, 0},
      '{KIND_SAMPLE, 32'h0001_0000, 0, 0, 0},
      '{KIND_LOAD, 0, 63, 32'h7FFF_FFFF, 0},
      '{KIND_LOAD, 0, 62, 32'h8000_0000, 0},
      '{KIND_READ, 0, 0, 0, 0},
      '{KIND_READ, 0, 63, 0, 0},
      '{KIND_CLEAR, 0, 21, 0, 1},
      '{KIND_READ, 0, 5, 0, 1},
      '{KIND_SAMPLE, -65536 * 40, 0, 0, 0},
      '{KIND_LOAD, 0, 62, 376, 0},
      '{KIND_LOAD, 0, 63, 384, 0},
      '{KIND_CLEAR, 32'hFFFF_FFFF, 63, 32'hFFFF_FFFF, 1}
    };

    // mode, scale, exact, start, step, used, idle percent, words
    setups = '{
      '{MODE_SCAN,   1,     0,   0,            1,          10,  0,  110},
      '{MODE_LINEAR, 1,     3,   -100,         7,          20,  70, 100},
      '{MODE_GEO,    1,     4,   -130,         1,          64,  0,  110},
      '{2'd3,        3,     64,  0,            0,          2,   38, 80},
      '{MODE_LINEAR, 65535, 127, 32'h8000_0000, 32'h7FFF_FFFF, 127, 70, 80},
      '{MODE_GEO,    65535, 0,   32'h7FFF_FFFF, 1,          0,   0,  60},
      '{MODE_SCAN,   300,   10,  -50,          3,          33,  38, 110},
      '{MODE_LINEAR, 1,     0,   -20,          0,          1,   0,  80},
      '{MODE_GEO,    2,     70,  -1000,        5,          40,  70, 60}
    };

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // fill the table with rising breakpoints before anything reads it
    for (int i = 0; i < NBKT; i++)
      send_word(KIND_LOAD, $urandom, 6'(i), -120 + i * 8, 0);

    foreach (dir_rows[i])
      send_word(dir_rows[i].kind, dir_rows[i].smp, dir_rows[i].ix, dir_rows[i].bval,
                dir_rows[i].zero_exp);

    foreach (setups[p]) begin
      drain();
      write_reg(CFG_BIN_MODE, setups[p].mode);
      write_reg(CFG_SCALE_FACTOR, setups[p].scale);
      write_reg(CFG_EXACT_COUNT, setups[p].exact);
      write_reg(CFG_RANGE_START, setups[p].rstart);
      write_reg(CFG_RANGE_STEP, setups[p].rstep);
      write_reg(CFG_BUCKETS_USED, setups[p].used);
      idle_pct = setups[p].idle_pct;
      for (int n = 0; n < setups[p].n; n++) begin
        sel = $urandom_range(99);
        ix = 6'($urandom);
        bv = -120 + int'(ix) * 8 + int'($urandom_range(6)) - 3;
        if ($urandom_range(3) == 0) bv = $urandom;
        if (sel < 80) k = KIND_SAMPLE;
        else if (sel < 90) k = KIND_LOAD;
        else if (sel < 97) k = KIND_READ;
        else k = KIND_CLEAR;
        // hold off once mid-phase until every result is back
        if (p == 1 && n == 50) drain();
        send_word(k, make_sample(), ix, bv, 0);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
